// ===== hw/rtl/dspq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dspq_pkg
// Shared widths and codes for the shortest path query engine.
// ----------------------------------------------------------------------------
package dspq_pkg;
	localparam int MAX_TOWNS   = 32;
	localparam int LENGTH_BITS = 16;
	localparam int DIST_BITS   = 24;
	localparam int TW          = $clog2(MAX_TOWNS);
	localparam int EW          = 2 * TW;

	localparam logic [0:0] CFG_TOWN_COUNT = 1'b0;
	localparam logic [0:0] CFG_INFINITY   = 1'b1;

	localparam logic KIND_EDGE  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/dijkstra_shortest_path_query.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_query
// Dense Dijkstra over an edge memory with one adder for the relax step.
// ----------------------------------------------------------------------------
// Edge word: the stored length is read and replaced if there is no edge yet
// or the new length is shorter. Query: per settled town a relax scan through
// the edge memory port and a minimum scan, then path walk and output words.
// One word at a time; the edge memory read port sets the pace.
// Reset sets the control registers and then runs a clearing pass over all
// MAX_TOWNS*MAX_TOWNS edge memory words before the first word is taken.
module dijkstra_shortest_path_query (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [5:0]  from_town,
	input  wire logic [5:0]  to_town,
	input  wire logic [15:0] edge_length,
	input  wire logic        list_path,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_path_entry,
	output logic [23:0]      path_distance,
	output logic [5:0]       via_town,
	output logic             last
);
	import dspq_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_EDGE = 4'd2,
		ST_INIT = 4'd3, ST_RELAX = 4'd4, ST_MIN = 4'd5, ST_WALK = 4'd6,
		ST_DIST = 4'd7, ST_POP = 4'd8, ST_RELAX_W = 4'd9, ST_FIN = 4'd10;

	logic [3:0] state_q;
	logic [6:0] town_count_q;
	logic [DIST_BITS-1:0] inf_q;
	logic [TW:0] n_w;
	assign n_w = (town_count_q < 7'(MAX_TOWNS)) ? (TW+1)'(town_count_q)
		: (TW+1)'(MAX_TOWNS);

	logic [LENGTH_BITS:0] emem [MAX_TOWNS*MAX_TOWNS];
	logic [LENGTH_BITS:0] erd_q;
	logic [EW-1:0] ea, ewa;
	logic ewe;
	logic [LENGTH_BITS:0] ewd;

	logic [DIST_BITS-1:0] bd_q [MAX_TOWNS];
	logic [MAX_TOWNS-1:0] st_q;
	logic [TW-1:0] pred_q [MAX_TOWNS];
	logic [TW-1:0] stk_q [MAX_TOWNS];

	logic [EW:0] clr_q;
	logic [TW-1:0] src_q, dst_q, cur_q, nxt_q, walk_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic lp_q, fnd_q, wv_q;
	logic [DIST_BITS-1:0] nd_q;
	logic [TW:0] i_q, dep_q;

	always_ff @(posedge clk) begin
		if (ewe)
			emem[ewa] <= ewd;
		erd_q <= emem[ea];
	end

	logic [DIST_BITS:0] sum_w;
	logic [DIST_BITS-1:0] sat_w;
	assign sum_w = {1'b0, bd_q[cur_q]} + (DIST_BITS+1)'(erd_q[LENGTH_BITS-1:0]);
	assign sat_w = sum_w[DIST_BITS] ? {DIST_BITS{1'b1}} : sum_w[DIST_BITS-1:0];
	logic [TW-1:0] iw;
	assign iw = i_q[TW-1:0];

	always_comb begin
		ea = {src_q, dst_q};
		ewe = 1'b0;
		ewa = {src_q, dst_q};
		ewd = {1'b1, len_q};
		unique case (state_q)
			ST_CLEAR: begin
				ewe = 1'b1;
				ewa = clr_q[EW-1:0];
				ewd = '0;
			end
			ST_IDLE: ea = {from_town[TW-1:0], to_town[TW-1:0]};
			ST_EDGE: ewe = !erd_q[LENGTH_BITS] || len_q < erd_q[LENGTH_BITS-1:0];
			ST_RELAX, ST_RELAX_W: ea = {cur_q, iw};
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			town_count_q <= 7'd32;
			inf_q <= '1;
			clr_q <= '0;
			out_valid <= 1'b0;
			i_q <= '0;
			dep_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TOWN_COUNT: town_count_q <= cfg_data[6:0];
					CFG_INFINITY: inf_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready && state_q != ST_POP)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (EW+1)'(MAX_TOWNS*MAX_TOWNS-1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid && in_ready) begin
					src_q <= from_town[TW-1:0];
					dst_q <= to_town[TW-1:0];
					len_q <= edge_length[LENGTH_BITS-1:0];
					lp_q <= list_path;
					if (kind == KIND_EDGE) begin
						if ((TW+1)'(from_town) < n_w && (TW+1)'(to_town) < n_w
							&& from_town < 6'(MAX_TOWNS) && to_town < 6'(MAX_TOWNS))
							state_q <= ST_EDGE;
					end else if ((7'(from_town) < 7'(n_w)) && (7'(to_town) < 7'(n_w))) begin
						i_q <= '0;
						state_q <= ST_INIT;
					end else begin
						out_valid <= 1'b1;
						is_path_entry <= 1'b0;
						path_distance <= inf_q;
						via_town <= '0;
						last <= 1'b1;
					end
				end
				ST_EDGE: state_q <= ST_IDLE;
				ST_INIT: begin
					bd_q[iw] <= (iw == src_q) ? '0 : inf_q;
					st_q[iw] <= 1'b0;
					pred_q[iw] <= iw;
					if (i_q == n_w - 1'b1) begin
						cur_q <= src_q;
						state_q <= ST_FIN;
					end
					i_q <= i_q + 1'b1;
				end
				ST_FIN: begin
					st_q[cur_q] <= 1'b1;
					i_q <= '0;
					if (cur_q == dst_q)
						state_q <= ST_DIST;
					else
						state_q <= ST_RELAX_W;
				end
				ST_RELAX_W: state_q <= ST_RELAX;
				ST_RELAX: begin
					// erd_q holds edge cur->iw, read last cycle
					if (erd_q[LENGTH_BITS] && sat_w < bd_q[iw]) begin
						bd_q[iw] <= sat_w;
						pred_q[iw] <= cur_q;
					end
					if (i_q == n_w - 1'b1) begin
						i_q <= '0;
						fnd_q <= 1'b0;
						nd_q <= inf_q;
						state_q <= ST_MIN;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_RELAX_W;
					end
				end
				ST_MIN: begin
					if (!st_q[iw] && bd_q[iw] < nd_q) begin
						nxt_q <= iw;
						nd_q <= bd_q[iw];
						fnd_q <= 1'b1;
					end
					if (i_q == n_w - 1'b1) begin
						if (fnd_q || (!st_q[iw] && bd_q[iw] < nd_q)) begin
							cur_q <= (!st_q[iw] && bd_q[iw] < nd_q) ? iw : nxt_q;
							state_q <= ST_FIN;
						end else
							state_q <= ST_DIST;
					end
					i_q <= i_q + 1'b1;
				end
				ST_DIST: begin
					dep_q <= '0;
					walk_q <= pred_q[dst_q];
					if (bd_q[dst_q] >= inf_q || !st_q[dst_q]) begin
						out_valid <= 1'b1;
						is_path_entry <= 1'b0;
						path_distance <= inf_q;
						via_town <= '0;
						last <= 1'b1;
						state_q <= ST_IDLE;
					end else if (lp_q)
						state_q <= ST_WALK;
					else begin
						wv_q <= 1'b0;
						state_q <= ST_POP;
					end
					nd_q <= bd_q[dst_q];
				end
				ST_WALK: begin
					if (walk_q != src_q && dep_q < (TW+1)'(MAX_TOWNS-2)
						&& (TW+1)'(walk_q) < n_w) begin
						stk_q[dep_q[TW-1:0]] <= walk_q;
						dep_q <= dep_q + 1'b1;
						walk_q <= pred_q[walk_q];
					end else begin
						wv_q <= 1'b0;
						state_q <= ST_POP;
					end
				end
				ST_POP: if (!out_valid || out_ready) begin
					out_valid <= 1'b1;
					if (!wv_q) begin
						wv_q <= 1'b1;
						is_path_entry <= 1'b0;
						path_distance <= nd_q;
						via_town <= '0;
						last <= (dep_q == '0);
						if (dep_q == '0)
							state_q <= ST_IDLE;
					end else begin
						is_path_entry <= 1'b1;
						path_distance <= '0;
						via_town <= 6'(stk_q[dep_q[TW-1:0] - 1'b1]);
						last <= (dep_q == (TW+1)'(1));
						dep_q <= dep_q - 1'b1;
						if (dep_q == (TW+1)'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
